>>> design/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared widths and sector codes for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvc_pkg;

   localparam int HUE_BITS_DEF     = 16;
   localparam int CHANNEL_BITS_DEF = 8;

   // colour wheel sector, from hue * 6
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

endpackage

>>> design/hsvc_if.sv
// ----------------------------------------------------------------------------
// hsvc_req_if / hsvc_rsp_if
// Valid/ready channels carrying HSV words in and RGB words out.
// ----------------------------------------------------------------------------
interface hsvc_req_if #(
   parameter int HUE_BITS     = hsvc_pkg::HUE_BITS_DEF,
   parameter int CHANNEL_BITS = hsvc_pkg::CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [HUE_BITS-1:0]     hue;
   logic [CHANNEL_BITS-1:0] saturation;
   logic [CHANNEL_BITS-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsvc_rsp_if #(
   parameter int CHANNEL_BITS = hsvc_pkg::CHANNEL_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> design/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Five-stage pipelined HSV to RGB colour conversion, exact integer floors.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake            | word
//  req_port  | in  | valid/ready          | hue, saturation, brightness
//  rsp_port  | out | valid/ready          | red, green, blue
//
//  One word per cycle sustained while rsp_port ready stays high.
//  Stages: hue*6, s*f, level numerators with v*(M-s), v*level, divide by M
//  and sector routing into the output register.
//  Reset (synchronous) clears the stage valid bits only.
//  A stall backs up stage by stage; empty stages still fill, so req ready
//  drops only when every stage holds a word.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit #(
   parameter int HUE_BITS     = hsvc_pkg::HUE_BITS_DEF,
   parameter int CHANNEL_BITS = hsvc_pkg::CHANNEL_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   hsvc_req_if.sink     req_port,
   hsvc_rsp_if.source   rsp_port
);
   import hsvc_pkg::*;

   localparam int H    = HUE_BITS;
   localparam int C    = CHANNEL_BITS;
   localparam int NSTG = 5;
   localparam logic [C-1:0]   CH_MAX  = {C{1'b1}};
   localparam logic [C:0]     TWO_MAX = {CH_MAX, 1'b0};
   localparam logic [C+H-1:0] FULL    = {CH_MAX, {H{1'b0}}};

   function automatic logic [C-1:0] div_max(input logic [2*C-1:0] x);
      logic [C-1:0] hi;
      logic [C:0]   rem;
      hi  = x[2*C-1:C];
      rem = {1'b0, x[C-1:0]} + {1'b0, hi};
      return hi + C'(rem >= {1'b0, CH_MAX}) + C'(rem >= TWO_MAX);
   endfunction

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   // stage 1
   logic [H+2:0]   h6_in;
   sector_type     sec1_ff;
   logic [H-1:0]   f1_ff;
   logic [C-1:0]   s1_ff, v1_ff;
   // stage 2
   sector_type     sec2_ff;
   logic [C+H-1:0] sf2_ff;
   logic [C-1:0]   ms2_ff, v2_ff;
   // stage 3
   sector_type     sec3_ff;
   logic [C+H-1:0] aq3_ff, at3_ff;
   logic [2*C-1:0] pn3_ff;
   logic [C-1:0]   v3_ff;
   // stage 4
   logic [2*C+H-1:0] nq_in, nt_in;
   sector_type     sec4_ff;
   logic [2*C-1:0] xq4_ff, xt4_ff, xp4_ff;
   logic [C-1:0]   v4_ff;
   // stage 5
   logic [C-1:0]   p_in, q_in, t_in;
   logic [C-1:0]   red_in, green_in, blue_in;
   logic [C-1:0]   red_ff, green_ff, blue_ff;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_port.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_port.valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign h6_in = ((H+3)'(req_port.hue) << 2) + ((H+3)'(req_port.hue) << 1);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec1_ff <= sector_type'(h6_in[H+2:H]);
         f1_ff   <= h6_in[H-1:0];
         s1_ff   <= req_port.saturation;
         v1_ff   <= req_port.brightness;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sec2_ff <= sec1_ff;
         sf2_ff  <= (C+H)'(s1_ff) * (C+H)'(f1_ff);
         ms2_ff  <= CH_MAX - s1_ff;
         v2_ff   <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sec3_ff <= sec2_ff;
         aq3_ff  <= FULL - sf2_ff;
         at3_ff  <= {ms2_ff, {H{1'b0}}} + sf2_ff;
         pn3_ff  <= (2*C)'(v2_ff) * (2*C)'(ms2_ff);
         v3_ff   <= v2_ff;
      end
   end

   assign nq_in = (2*C+H)'(v3_ff) * (2*C+H)'(aq3_ff);
   assign nt_in = (2*C+H)'(v3_ff) * (2*C+H)'(at3_ff);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         sec4_ff <= sec3_ff;
         xq4_ff  <= nq_in[2*C+H-1:H];
         xt4_ff  <= nt_in[2*C+H-1:H];
         xp4_ff  <= pn3_ff;
         v4_ff   <= v3_ff;
      end
   end

   assign p_in = div_max(xp4_ff);
   assign q_in = div_max(xq4_ff);
   assign t_in = div_max(xt4_ff);

   always_comb begin
      case (sec4_ff)
         SEC_RED_YEL: begin red_in = v4_ff; green_in = t_in;  blue_in = p_in;  end
         SEC_YEL_GRN: begin red_in = q_in;  green_in = v4_ff; blue_in = p_in;  end
         SEC_GRN_CYN: begin red_in = p_in;  green_in = v4_ff; blue_in = t_in;  end
         SEC_CYN_BLU: begin red_in = p_in;  green_in = q_in;  blue_in = v4_ff; end
         SEC_BLU_MAG: begin red_in = t_in;  green_in = p_in;  blue_in = v4_ff; end
         default:     begin red_in = v4_ff; green_in = p_in;  blue_in = q_in;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign req_port.ready = adv[0];
   assign rsp_port.valid = vld_ff[NSTG-1];
   assign rsp_port.red   = red_ff;
   assign rsp_port.green = green_ff;
   assign rsp_port.blue  = blue_ff;

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> vld_ff[0])
      else $error("accepted word not captured in first stage");

   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> (&vld_ff))
      else $error("input stalled while a stage is empty");

   a_levels_bounded : assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (p_in <= v4_ff) && (q_in <= v4_ff) && (t_in <= v4_ff))
      else $error("level exceeds brightness");

   a_grey_held : assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] && (ms2_ff == CH_MAX) && adv[2] |=> (pn3_ff == (2*C)'(v3_ff) * (2*C)'(CH_MAX)))
      else $error("zero saturation level wrong");

endmodule

>>> test/hsv_to_rgb_converter_checker.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// Watches both channels of the converter, predicts the RGB word for every
// accepted HSV word with exact integer floors, and compares in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [hsvc_pkg::HUE_BITS_DEF-1:0]     req_hue,
   input  logic [hsvc_pkg::CHANNEL_BITS_DEF-1:0] req_saturation,
   input  logic [hsvc_pkg::CHANNEL_BITS_DEF-1:0] req_brightness,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [hsvc_pkg::CHANNEL_BITS_DEF-1:0] rsp_red,
   input  logic [hsvc_pkg::CHANNEL_BITS_DEF-1:0] rsp_green,
   input  logic [hsvc_pkg::CHANNEL_BITS_DEF-1:0] rsp_blue,
   output int                                    error_count,
   output int                                    outstanding,
   output int                                    checked_count
);
   import hsvc_pkg::*;

   localparam int CB = CHANNEL_BITS_DEF;
   localparam int HB = HUE_BITS_DEF;
   localparam longint unsigned CH_MAX  = (64'd1 << CB) - 64'd1;
   localparam longint unsigned HUE_ONE = 64'd1 << HB;

   typedef struct packed {
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
   } rgb_word_type;

   rgb_word_type colour_q[$];
   int           miss_total  = 0;
   int           match_total = 0;

   function automatic rgb_word_type rgb_of_hsv(input logic [HB-1:0] hue,
                                               input logic [CB-1:0] sat,
                                               input logic [CB-1:0] bright);
      longint unsigned scale;
      longint unsigned v;
      longint unsigned s;
      longint unsigned h6;
      longint unsigned f;
      longint unsigned p;
      longint unsigned q;
      longint unsigned t;
      sector_type      sector;
      rgb_word_type    c;
      scale  = CH_MAX * HUE_ONE;
      v      = 64'(bright);
      s      = 64'(sat);
      h6     = 64'(hue) * 64'd6;
      sector = sector_type'(h6 >> HB);
      f      = h6 & (HUE_ONE - 64'd1);
      p      = v * (CH_MAX - s) / CH_MAX;
      q      = v * (scale - s * f) / scale;
      t      = v * (scale - s * (HUE_ONE - f)) / scale;
      if (s == 0) begin
         c = '{red: CB'(v), green: CB'(v), blue: CB'(v)};
      end else begin
         case (sector)
            SEC_RED_YEL: c = '{red: CB'(v), green: CB'(t), blue: CB'(p)};
            SEC_YEL_GRN: c = '{red: CB'(q), green: CB'(v), blue: CB'(p)};
            SEC_GRN_CYN: c = '{red: CB'(p), green: CB'(v), blue: CB'(t)};
            SEC_CYN_BLU: c = '{red: CB'(p), green: CB'(q), blue: CB'(v)};
            SEC_BLU_MAG: c = '{red: CB'(t), green: CB'(p), blue: CB'(v)};
            default:     c = '{red: CB'(v), green: CB'(p), blue: CB'(q)};
         endcase
      end
      return c;
   endfunction

   task automatic compare_channel(input string name, input logic [CB-1:0] want,
                                  input logic [CB-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         miss_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      rgb_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (colour_q.size() == 0) begin
               $display("%0t: unexpected rgb word, expected none, actual %0d %0d %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               miss_total++;
            end else begin
               want = colour_q.pop_front();
               compare_channel("red", want.red, rsp_red);
               compare_channel("green", want.green, rsp_green);
               compare_channel("blue", want.blue, rsp_blue);
               match_total++;
            end
         end
         if (req_valid && req_ready)
            colour_q.insert(colour_q.size(),
                            rgb_of_hsv(req_hue, req_saturation, req_brightness));
      end
      error_count   <= miss_total;
      checked_count <= match_total;
      outstanding   <= colour_q.size();
   end

endmodule

>>> test/tb_hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// Drives HSV words into the converter with random gaps and output stalls,
// including a long output hold-off and a full drain, and reports the verdict
// from the checker's error and outstanding counts.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_unit;
   import hsvc_pkg::*;

   localparam int HOLD_CYCLES    = 160;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 20;

   logic clock        = 1'b0;
   logic reset        = 1'b1;
   logic steady_flow  = 1'b0;
   int   hold_asks    = 0;
   int   pixels_sent  = 0;
   int   quiet_cycles = 0;
   int   error_count;
   int   outstanding;
   int   checked_count;

   hsvc_req_if req_if ();
   hsvc_rsp_if rsp_if ();

   hsv_to_rgb_converter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   hsv_to_rgb_converter_checker colour_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_hue        (req_if.hue),
      .req_saturation (req_if.saturation),
      .req_brightness (req_if.brightness),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_red        (rsp_if.red),
      .rsp_green      (rsp_if.green),
      .rsp_blue       (rsp_if.blue),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : ready_drive
      int holds_done;
      holds_done   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_asks) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= steady_flow || ($urandom_range(99) >= 26);
      end
   end

   function automatic logic [HUE_BITS_DEF-1:0] sector_start(input int k);
      return HUE_BITS_DEF'((k * 65536 + 5) / 6);
   endfunction

   function automatic logic [HUE_BITS_DEF-1:0] pick_hue();
      if ($urandom_range(99) < 15)
         return sector_start($urandom_range(5)) + HUE_BITS_DEF'($urandom_range(2))
                - HUE_BITS_DEF'(1);
      return HUE_BITS_DEF'($urandom_range(65535));
   endfunction

   function automatic logic [CHANNEL_BITS_DEF-1:0] pick_level();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      if (r < 25) return CHANNEL_BITS_DEF'(1);
      if (r < 30) return CHANNEL_BITS_DEF'(254);
      return CHANNEL_BITS_DEF'($urandom_range(255));
   endfunction

   task automatic offer_pixel(input logic [HUE_BITS_DEF-1:0]     hue,
                              input logic [CHANNEL_BITS_DEF-1:0] sat,
                              input logic [CHANNEL_BITS_DEF-1:0] bright);
      while (!steady_flow && $urandom_range(99) < 26) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.hue        <= hue;
      req_if.saturation <= sat;
      req_if.brightness <= bright;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.hue        = '0;
      req_if.saturation = '0;
      req_if.brightness = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 6; k++) begin
         offer_pixel(sector_start(k), 8'hFF, 8'hFF);
         offer_pixel(sector_start(k) - HUE_BITS_DEF'(1), 8'hFF, 8'hFF);
      end
      offer_pixel(16'h0000, 8'h00, 8'hC8);
      offer_pixel(16'h9C40, 8'h00, 8'hFF);
      offer_pixel(16'h3039, 8'hFF, 8'h00);
      offer_pixel(16'h0000, 8'h00, 8'h00);
      offer_pixel(16'hAAAA, 8'h55, 8'hAA);
      offer_pixel(16'h5555, 8'hAA, 8'h55);
      offer_pixel(16'h7530, 8'h80, 8'h4D);
      offer_pixel(16'hFFFF, 8'h01, 8'hFF);
      offer_pixel(sector_start(3) + HUE_BITS_DEF'(1), 8'hFE, 8'h01);

      repeat (700) offer_pixel(pick_hue(), pick_level(), pick_level());

      // hold the input until the pipeline has drained
      req_if.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);

      steady_flow = 1'b1;
      hold_asks   = hold_asks + 1;
      repeat (500) offer_pixel(pick_hue(), pick_level(), pick_level());
      steady_flow = 1'b0;

      repeat (600) offer_pixel(pick_hue(), pick_level(), pick_level());

      req_if.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered: %0d hsv words in, %0d rgb words checked, all six sectors",
               pixels_sent, checked_count);
      $display("covered: sector edges, grey, black, full scale, %0d-cycle output hold-off",
               HOLD_CYCLES);
      if (error_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
